// ----- rtl/core/wmr_pkg.sv -----
package wmr_pkg;

    localparam int MAX_VARS = 8;
    localparam int MAX_DEG  = 255;
    localparam int TOP_MAX  = MAX_DEG + 1;
    localparam int TAB_SIZE = MAX_VARS * (MAX_DEG + 1) + 1;
    localparam int TAB_AW   = $clog2(TAB_SIZE);
    localparam int CS_DEPTH = MAX_DEG + 1;
    localparam int CS_AW    = $clog2(CS_DEPTH);

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_BUILD    = 2'd0,
        REQ_ENCODE   = 2'd1,
        REQ_DECODE   = 2'd2,
        REQ_MULTIPLY = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DEGREE = 2'd1,
        STAT_RANK   = 2'd2
    } status_t;

    localparam logic [3:0] CFG_NUM_VARS    = 4'd0;
    localparam logic [3:0] CFG_VAR_WEIGHTS = 4'd1;
    localparam logic [3:0] CFG_MAX_DEGREE  = 4'd2;
    localparam logic [3:0] CFG_LAST_STEP   = 4'd3;

endpackage

// ----- rtl/core/weighted_monomial_rank_unrank_top.sv -----
// Build: counts the monomials per degree, then fills the rank table; every table element
//   is read and then written back on the rank table port.
// Encode reads one rank table entry per variable. Decode and multiply search the final
//   column and then walk the columns down, all on the rank table port.
// One request is in flight at a time; a finished result waits in the output register.
// Reset clears the control state and configuration; the memories are not cleared, and
//   until a build has run, every other request answers with an error status.
module weighted_monomial_rank_unrank_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_rank_in,
    input  logic [7:0]  s_exp_0,
    input  logic [7:0]  s_exp_1,
    input  logic [7:0]  s_exp_2,
    input  logic [7:0]  s_exp_3,
    input  logic [7:0]  s_exp_4,
    input  logic [7:0]  s_exp_5,
    input  logic [7:0]  s_exp_6,
    input  logic [7:0]  s_exp_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_rank_out,
    output logic [7:0]  m_dec_0,
    output logic [7:0]  m_dec_1,
    output logic [7:0]  m_dec_2,
    output logic [7:0]  m_dec_3,
    output logic [7:0]  m_dec_4,
    output logic [7:0]  m_dec_5,
    output logic [7:0]  m_dec_6,
    output logic [7:0]  m_dec_7,
    output logic [7:0]  m_top_degree,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NV = wmr_pkg::MAX_VARS;
    localparam int AW = wmr_pkg::TAB_AW;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FILL_CS, S_CNT_RD, S_CNT_WR, S_MAX_RD, S_MAX_WR,
        S_FILL_RT, S_PFX_RD, S_PFX_WR, S_TERM, S_ENC, S_ENC_ACC, S_SRCH_FIRST,
        S_SRCH_UP, S_SRCH_DN, S_WALK_A, S_WALK_B, S_WALK_C, S_WALK_W, S_FIN
    } state_t;

    typedef struct packed {
        logic [9:0] k;
        logic [3:0] j;
        logic       first;
        logic       col_done;
    } adv_t;

    function automatic logic [AW-1:0] tab_addr(input logic [3:0] col, input logic [9:0] k,
                                               input logic [8:0] top);
        logic [13:0] p;
        p = 14'(col) * 14'(top) + 14'(k);
        return p[AW-1:0];
    endfunction

    // Next element of a strided column walk: the same residue class first, then the next one.
    function automatic adv_t advance(input logic [9:0] k, input logic [3:0] j,
                                     input logic [3:0] step, input logic [8:0] top);
        adv_t       a;
        logic [9:0] kn;
        logic [4:0] jn;
        kn = k + {6'b0, step};
        jn = {1'b0, j} + 5'd1;
        a.k = kn;
        a.j = j;
        a.first = 1'b0;
        a.col_done = 1'b0;
        if (kn < {1'b0, top}) begin
            a.col_done = 1'b0;
        end else if (jn < {1'b0, step} && {4'b0, jn} < top) begin
            a.k = {5'b0, jn};
            a.j = jn[3:0];
            a.first = 1'b1;
        end else begin
            a.col_done = 1'b1;
        end
        return a;
    endfunction

    // Configuration
    logic [3:0]  num_vars_reg;
    logic [31:0] var_weights_reg;
    logic [7:0]  max_degree_reg;
    logic [3:0]  last_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg    <= 4'd1;
            var_weights_reg <= 32'h1111_1111;
            max_degree_reg  <= 8'd255;
            last_step_reg   <= 4'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wmr_pkg::CFG_NUM_VARS:    num_vars_reg    <= cfg_data[3:0];
                wmr_pkg::CFG_VAR_WEIGHTS: var_weights_reg <= cfg_data;
                wmr_pkg::CFG_MAX_DEGREE:  max_degree_reg  <= cfg_data[7:0];
                wmr_pkg::CFG_LAST_STEP:   last_step_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Memories
    logic [63:0]              rt_mem [wmr_pkg::TAB_SIZE];
    logic [63:0]              cs_mem [wmr_pkg::CS_DEPTH];
    logic                     rt_we, cs_we;
    logic [AW-1:0]            rt_waddr, rt_raddr;
    logic [wmr_pkg::CS_AW-1:0] cs_waddr, cs_raddr;
    logic [63:0]              rt_wdata, cs_wdata, rt_rdata, cs_rdata;

    always_ff @(posedge aclk) begin
        if (rt_we) begin
            rt_mem[rt_waddr] <= rt_wdata;
        end
        rt_rdata <= rt_mem[rt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cs_we) begin
            cs_mem[cs_waddr] <= cs_wdata;
        end
        cs_rdata <= cs_mem[cs_raddr];
    end

    // Control and datapath registers
    state_t            state_reg, state_next;
    wmr_pkg::req_t     req_reg, req_next;
    wmr_pkg::status_t  status_reg, status_next;
    logic [63:0]       v_reg, v_next;
    logic [63:0]       s_reg, s_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       max_rank_reg, max_rank_next;
    logic [7:0]        e_reg [NV];
    logic [7:0]        e_next [NV];
    logic [7:0]        dec_reg [NV];
    logic [7:0]        dec_next [NV];
    logic [3:0]        bw_reg [NV+1];
    logic [3:0]        bw_next [NV+1];
    logic [3:0]        bn_reg, bn_next;
    logic [8:0]        eff_top_reg, eff_top_next;
    logic [8:0]        degree_hint_reg, degree_hint_next;
    logic [3:0]        col_reg, col_next;
    logic [3:0]        j_reg, j_next;
    logic [9:0]        k_reg, k_next;
    logic [8:0]        d_reg, d_next;
    logic [3:0]        rem_reg, rem_next;
    logic              first_reg, first_next;
    logic              sum_phase_reg, sum_phase_next;
    logic              chg_reg, chg_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [63:0]       m_rank_reg, m_rank_next;
    logic [7:0]        m_dec_reg [NV];
    logic [7:0]        m_dec_next [NV];
    logic [7:0]        m_top_reg, m_top_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        adv_t        adv;
        logic [3:0]  step;
        logic [3:0]  nv;
        logic [3:0]  wt;
        logic [3:0]  ls;
        logic [63:0] acc_base;
        logic [64:0] sum65;
        logic [8:0]  top_now;
        logic [8:0]  dclip;
        logic [7:0]  e_cur;
        logic [9:0]  d_e;
        logic [3:0]  up;
        logic        ok;

        state_next       = state_reg;
        req_next         = req_reg;
        status_next      = status_reg;
        v_next           = v_reg;
        s_next           = s_reg;
        acc_next         = acc_reg;
        max_rank_next    = max_rank_reg;
        e_next           = e_reg;
        dec_next         = dec_reg;
        bw_next          = bw_reg;
        bn_next          = bn_reg;
        eff_top_next     = eff_top_reg;
        degree_hint_next = degree_hint_reg;
        col_next         = col_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        d_next           = d_reg;
        rem_next         = rem_reg;
        first_next       = first_reg;
        sum_phase_next   = sum_phase_reg;
        chg_next         = chg_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_rank_next      = m_rank_reg;
        m_dec_next       = m_dec_reg;
        m_top_next       = m_top_reg;

        rt_we    = 1'b0;
        rt_waddr = '0;
        rt_wdata = '0;
        rt_raddr = '0;
        cs_we    = 1'b0;
        cs_waddr = k_reg[wmr_pkg::CS_AW-1:0];
        cs_wdata = '0;
        cs_raddr = k_reg[wmr_pkg::CS_AW-1:0];

        adv      = '0;
        step     = bw_reg[col_reg];
        nv       = 4'd1;
        wt       = 4'd0;
        ls       = 4'd1;
        acc_base = first_reg ? 64'd0 : acc_reg;
        sum65    = '0;
        top_now  = eff_top_reg;
        dclip    = degree_hint_reg;
        e_cur    = e_reg[col_reg[2:0]];
        d_e      = {1'b0, d_reg} + {2'b0, e_cur};
        up       = bw_reg[4'(col_reg + 4'd1)];
        ok       = (status_reg == wmr_pkg::STAT_OK);

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = wmr_pkg::req_t'(s_req_type);
                    v_next   = s_rank_in;
                    e_next[0] = s_exp_0;
                    e_next[1] = s_exp_1;
                    e_next[2] = s_exp_2;
                    e_next[3] = s_exp_3;
                    e_next[4] = s_exp_4;
                    e_next[5] = s_exp_5;
                    e_next[6] = s_exp_6;
                    e_next[7] = s_exp_7;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                status_next = wmr_pkg::STAT_OK;
                s_next = 64'd0;
                for (int i = 0; i < NV; i++) begin
                    dec_next[i] = 8'd0;
                end
                if (req_reg == wmr_pkg::REQ_BUILD) begin
                    if (num_vars_reg == 4'd0) begin
                        nv = 4'd1;
                    end else if (num_vars_reg > 4'(NV)) begin
                        nv = 4'(NV);
                    end else begin
                        nv = num_vars_reg;
                    end
                    for (int i = 0; i < NV; i++) begin
                        wt = var_weights_reg[4*i +: 4];
                        if (i < int'(nv)) begin
                            bw_next[i] = (wt == 4'd0) ? 4'd1 : wt;
                        end
                    end
                    ls = (last_step_reg == 4'd0) ? 4'd1 : last_step_reg;
                    bw_next[nv] = ls;
                    bn_next = nv;
                    eff_top_next = {1'b0, max_degree_reg} + 9'd1;
                    k_next = 10'd0;
                    state_next = S_FILL_CS;
                end else if (eff_top_reg == 9'd0) begin
                    status_next = (req_reg == wmr_pkg::REQ_ENCODE) ? wmr_pkg::STAT_DEGREE
                                                                    : wmr_pkg::STAT_RANK;
                    state_next = S_FIN;
                end else if (req_reg == wmr_pkg::REQ_ENCODE) begin
                    col_next = 4'd0;
                    state_next = S_ENC;
                end else if (v_reg > max_rank_reg) begin
                    status_next = wmr_pkg::STAT_RANK;
                    state_next = S_FIN;
                end else begin
                    if (degree_hint_reg == 9'd0) begin
                        dclip = 9'd1;
                    end else if (degree_hint_reg > eff_top_reg) begin
                        dclip = eff_top_reg;
                    end
                    col_next = bn_reg - 4'd1;
                    d_next = dclip;
                    rt_raddr = tab_addr(bn_reg - 4'd1, {1'b0, dclip}, eff_top_reg);
                    state_next = S_SRCH_FIRST;
                end
            end

            S_FILL_CS: begin
                cs_we = 1'b1;
                cs_wdata = 64'd1;
                if (k_reg + 10'd1 == {1'b0, eff_top_reg}) begin
                    col_next = 4'd0;
                    j_next = 4'd0;
                    k_next = 10'd0;
                    first_next = 1'b1;
                    state_next = S_CNT_RD;
                end else begin
                    k_next = k_reg + 10'd1;
                end
            end

            S_CNT_RD: begin
                state_next = S_CNT_WR;
            end

            S_CNT_WR: begin
                sum65 = {1'b0, acc_base} + {1'b0, cs_rdata};
                if (!first_reg && sum65 >= {1'b0, wmr_pkg::ALL_ONES}) begin
                    // The running count would reach all ones: the top degree stops here.
                    top_now = k_reg[8:0];
                    eff_top_next = top_now;
                end else begin
                    acc_next = sum65[63:0];
                    cs_we = !first_reg;
                    cs_wdata = sum65[63:0];
                end
                adv = advance(k_reg, j_reg, step, top_now);
                k_next = adv.k;
                j_next = adv.j;
                first_next = adv.first;
                state_next = S_CNT_RD;
                if (adv.col_done) begin
                    j_next = 4'd0;
                    k_next = 10'd0;
                    first_next = 1'b1;
                    if (col_reg + 4'd1 < bn_reg) begin
                        col_next = col_reg + 4'd1;
                    end else begin
                        state_next = S_MAX_RD;
                    end
                end
            end

            S_MAX_RD: begin
                cs_raddr = 8'(eff_top_reg - 9'd1);
                state_next = S_MAX_WR;
            end

            S_MAX_WR: begin
                max_rank_next = cs_rdata - 64'd1;
                k_next = 10'd0;
                rem_next = 4'd0;
                state_next = S_FILL_RT;
            end

            S_FILL_RT: begin
                rt_we = 1'b1;
                rt_waddr = AW'(k_reg);
                rt_wdata = (rem_reg == 4'd0) ? 64'd1 : 64'd0;
                rem_next = (rem_reg + 4'd1 == bw_reg[0]) ? 4'd0 : rem_reg + 4'd1;
                if (k_reg + 10'd1 == {1'b0, eff_top_reg}) begin
                    j_next = 4'd0;
                    k_next = 10'd0;
                    first_next = 1'b1;
                    if (bn_reg > 4'd1) begin
                        col_next = 4'd1;
                        sum_phase_next = 1'b1;
                    end else begin
                        col_next = 4'd0;
                        sum_phase_next = 1'b0;
                    end
                    state_next = S_PFX_RD;
                end else begin
                    k_next = k_reg + 10'd1;
                end
            end

            S_PFX_RD: begin
                rt_raddr = sum_phase_reg ? tab_addr(col_reg - 4'd1, k_reg, eff_top_reg)
                                         : tab_addr(col_reg, k_reg, eff_top_reg);
                state_next = S_PFX_WR;
            end

            S_PFX_WR: begin
                // The summing pass writes inclusive prefix sums into the next column; the
                // shifting pass turns a column into exclusive sums in place.
                sum65 = {1'b0, acc_base} + {1'b0, rt_rdata};
                rt_we = 1'b1;
                rt_waddr = tab_addr(col_reg, k_reg, eff_top_reg);
                rt_wdata = sum_phase_reg ? sum65[63:0] : acc_base;
                acc_next = sum65[63:0];
                step = sum_phase_reg ? bw_reg[col_reg] : up;
                adv = advance(k_reg, j_reg, step, eff_top_reg);
                k_next = adv.k;
                j_next = adv.j;
                first_next = adv.first;
                state_next = S_PFX_RD;
                if (adv.col_done) begin
                    j_next = 4'd0;
                    k_next = 10'd0;
                    first_next = 1'b1;
                    if (col_reg + 4'd1 < bn_reg) begin
                        col_next = col_reg + 4'd1;
                    end else if (sum_phase_reg) begin
                        sum_phase_next = 1'b0;
                        col_next = 4'd0;
                    end else begin
                        state_next = S_TERM;
                    end
                end
            end

            S_TERM: begin
                rt_we = 1'b1;
                rt_waddr = tab_addr(bn_reg, 10'd0, eff_top_reg);
                rt_wdata = wmr_pkg::ALL_ONES;
                degree_hint_next = 9'd1;
                s_next = max_rank_reg;
                state_next = S_FIN;
            end

            S_ENC: begin
                if ({1'b0, e_cur} > eff_top_reg - 9'd1) begin
                    status_next = wmr_pkg::STAT_DEGREE;
                    state_next = S_FIN;
                end else begin
                    rt_raddr = tab_addr(col_reg, {2'b0, e_cur}, eff_top_reg);
                    state_next = S_ENC_ACC;
                end
            end

            S_ENC_ACC: begin
                s_next = s_reg + rt_rdata;
                if (col_reg + 4'd1 == bn_reg) begin
                    state_next = S_FIN;
                end else begin
                    col_next = col_reg + 4'd1;
                    state_next = S_ENC;
                end
            end

            S_SRCH_FIRST, S_SRCH_UP: begin
                if (state_reg == S_SRCH_FIRST && rt_rdata > v_reg) begin
                    d_next = d_reg - 9'd1;
                    chg_next = 1'b0;
                    rt_raddr = tab_addr(col_reg, {1'b0, d_reg - 9'd1}, eff_top_reg);
                    state_next = S_SRCH_DN;
                end else if (d_reg < eff_top_reg && rt_rdata <= v_reg) begin
                    d_next = d_reg + 9'd1;
                    rt_raddr = tab_addr(col_reg, {1'b0, d_reg + 9'd1}, eff_top_reg);
                    state_next = S_SRCH_UP;
                end else begin
                    degree_hint_next = d_reg;
                    d_next = d_reg - 9'd1;
                    state_next = S_WALK_A;
                end
            end

            S_SRCH_DN: begin
                if (rt_rdata > v_reg && d_reg != 9'd0) begin
                    d_next = d_reg - 9'd1;
                    chg_next = 1'b1;
                    rt_raddr = tab_addr(col_reg, {1'b0, d_reg - 9'd1}, eff_top_reg);
                end else begin
                    if (rt_rdata > v_reg || chg_reg) begin
                        degree_hint_next = d_reg + 9'd1;
                    end
                    state_next = S_WALK_A;
                end
            end

            S_WALK_A: begin
                if (req_reg == wmr_pkg::REQ_MULTIPLY && d_e > {1'b0, eff_top_reg - 9'd1}) begin
                    status_next = wmr_pkg::STAT_DEGREE;
                    state_next = S_FIN;
                end else begin
                    if (req_reg == wmr_pkg::REQ_DECODE) begin
                        dec_next[col_reg[2:0]] = d_reg[7:0];
                    end
                    rt_raddr = (req_reg == wmr_pkg::REQ_MULTIPLY)
                             ? tab_addr(col_reg, d_e, eff_top_reg)
                             : tab_addr(col_reg, {1'b0, d_reg}, eff_top_reg);
                    state_next = S_WALK_B;
                end
            end

            S_WALK_B: begin
                if (req_reg == wmr_pkg::REQ_MULTIPLY) begin
                    s_next = s_reg + rt_rdata;
                end
                rt_raddr = tab_addr(col_reg, {1'b0, d_reg}, eff_top_reg);
                state_next = S_WALK_C;
            end

            S_WALK_C: begin
                v_next = v_reg - rt_rdata;
                if (col_reg == 4'd0) begin
                    state_next = S_FIN;
                end else begin
                    col_next = col_reg - 4'd1;
                    rt_raddr = tab_addr(col_reg - 4'd1, {1'b0, d_reg}, eff_top_reg);
                    state_next = S_WALK_W;
                end
            end

            S_WALK_W: begin
                // Step down the lower column by the weight above it while the entry is too big.
                if (d_reg >= {5'b0, up} && rt_rdata > v_reg) begin
                    d_next = d_reg - {5'b0, up};
                    rt_raddr = tab_addr(col_reg, {1'b0, d_reg - {5'b0, up}}, eff_top_reg);
                end else begin
                    state_next = S_WALK_A;
                end
            end

            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_status_next = status_reg;
                    m_rank_next = ok ? s_reg : 64'd0;
                    for (int i = 0; i < NV; i++) begin
                        m_dec_next[i] = ok ? dec_reg[i] : 8'd0;
                    end
                    m_top_next = (eff_top_reg != 9'd0) ? 8'(eff_top_reg - 9'd1) : 8'd0;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            eff_top_reg     <= 9'd0;
            max_rank_reg    <= 64'd0;
            degree_hint_reg <= 9'd1;
            bn_reg          <= 4'd1;
            for (int i = 0; i <= NV; i++) begin
                bw_reg[i] <= (i < 2) ? 4'd1 : 4'd0;
            end
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            eff_top_reg     <= eff_top_next;
            max_rank_reg    <= max_rank_next;
            degree_hint_reg <= degree_hint_next;
            bn_reg          <= bn_next;
            bw_reg          <= bw_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        status_reg    <= status_next;
        v_reg         <= v_next;
        s_reg         <= s_next;
        acc_reg       <= acc_next;
        e_reg         <= e_next;
        dec_reg       <= dec_next;
        col_reg       <= col_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        d_reg         <= d_next;
        rem_reg       <= rem_next;
        first_reg     <= first_next;
        sum_phase_reg <= sum_phase_next;
        chg_reg       <= chg_next;
        m_status_reg  <= m_status_next;
        m_rank_reg    <= m_rank_next;
        m_dec_reg     <= m_dec_next;
        m_top_reg     <= m_top_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_rank_out   = m_rank_reg;
    assign m_dec_0      = m_dec_reg[0];
    assign m_dec_1      = m_dec_reg[1];
    assign m_dec_2      = m_dec_reg[2];
    assign m_dec_3      = m_dec_reg[3];
    assign m_dec_4      = m_dec_reg[4];
    assign m_dec_5      = m_dec_reg[5];
    assign m_dec_6      = m_dec_reg[6];
    assign m_dec_7      = m_dec_reg[7];
    assign m_top_degree = m_top_reg;

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request did not reach dispatch");

    a_hint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (degree_hint_reg != 9'd0) && (degree_hint_reg <= 9'(wmr_pkg::TOP_MAX)))
        else $error("degree hint out of range");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish state");

    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH_UP) |-> (d_reg <= eff_top_reg))
        else $error("search degree past the top degree");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        wmr_pkg::req_t    kind;
        logic [63:0]      rank;
        logic [7:0]       exps [8];
    } mono_req_t;

    typedef struct {
        wmr_pkg::status_t status;
        logic [63:0]      rank;
        logic [7:0]       dec [8];
        logic [7:0]       top;
    } mono_res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [63:0] s_rank_in = '0;
    logic [7:0]  s_exp [8] = '{default: 8'd0};
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [63:0] m_rank_out;
    logic [7:0]  m_dec [8];
    logic [7:0]  m_top_degree;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    weighted_monomial_rank_unrank_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_rank_in(s_rank_in),
        .s_exp_0(s_exp[0]), .s_exp_1(s_exp[1]), .s_exp_2(s_exp[2]), .s_exp_3(s_exp[3]),
        .s_exp_4(s_exp[4]), .s_exp_5(s_exp[5]), .s_exp_6(s_exp[6]), .s_exp_7(s_exp[7]),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_rank_out(m_rank_out),
        .m_dec_0(m_dec[0]), .m_dec_1(m_dec[1]), .m_dec_2(m_dec[2]), .m_dec_3(m_dec[3]),
        .m_dec_4(m_dec[4]), .m_dec_5(m_dec[5]), .m_dec_6(m_dec[6]), .m_dec_7(m_dec[7]),
        .m_top_degree(m_top_degree),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Predictor state: configuration, latched build values and tables.
    int unsigned cf_nvars, cf_weights, cf_maxdeg, cf_step;
    int unsigned pm_top, pm_hint, pm_n;
    int unsigned pm_w [wmr_pkg::MAX_VARS + 1];
    bit [63:0]   pm_max_rank;
    bit [63:0]   pm_tab [wmr_pkg::TAB_SIZE];
    bit [63:0]   pm_cnt [wmr_pkg::CS_DEPTH];

    mono_req_t   pending_reqs [$];
    mono_res_t   expected_results [$];
    mono_req_t   cur_req;
    int          errors = 0;
    int          n_checked = 0;
    int          n_kind [4] = '{default: 0};
    int          n_bad_status = 0;
    bit          no_idle = 0;
    bit          hold_request = 0;
    bit          hold_done = 0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;

    function automatic bit [63:0] tab_rd(int unsigned col, int unsigned k);
        int unsigned a;
        a = col * pm_top + k;
        return (a < wmr_pkg::TAB_SIZE) ? pm_tab[a] : 64'd0;
    endfunction

    function automatic void tab_wr(int unsigned col, int unsigned k, bit [63:0] v);
        int unsigned a;
        a = col * pm_top + k;
        if (a < wmr_pkg::TAB_SIZE) pm_tab[a] = v;
    endfunction

    function automatic void build_rank_table();
        int unsigned n, top, d;
        int unsigned w [wmr_pkg::MAX_VARS + 1];
        bit [63:0] x, y;
        n = cf_nvars;
        if (n == 0) n = 1;
        if (n > wmr_pkg::MAX_VARS) n = wmr_pkg::MAX_VARS;
        for (int i = 0; i < n; i++) begin
            w[i] = (cf_weights >> (4 * i)) & 15;
            if (w[i] == 0) w[i] = 1;
        end
        w[n] = cf_step ? cf_step : 1;
        top = (cf_maxdeg > wmr_pkg::MAX_DEG ? wmr_pkg::MAX_DEG : cf_maxdeg) + 1;
        for (int k = 0; k < top; k++) pm_cnt[k] = 1;
        // Count monomials per degree, cutting the top back where a count would overflow.
        for (int i = 0; i < n; i++) begin
            d = w[i];
            for (int j = 0; j < d; j++) begin
                if (j + d < top) begin
                    x = pm_cnt[j];
                    for (int unsigned k = j + d; k < top; k += d) begin
                        y = pm_cnt[k];
                        if (64'hFFFF_FFFF_FFFF_FFFF - y <= x) top = k;
                        else begin
                            x += y;
                            pm_cnt[k] = x;
                        end
                    end
                end
            end
        end
        pm_max_rank = pm_cnt[top - 1] - 64'd1;
        pm_top = top;
        for (int unsigned k = 0; k < top; k++) tab_wr(0, k, (k % w[0]) == 0 ? 64'd1 : 64'd0);
        for (int unsigned i = 1; i < n; i++) begin
            d = w[i];
            for (int unsigned j = 0; j < d && j < top; j++) begin
                x = tab_rd(i - 1, j);
                tab_wr(i, j, x);
                for (int unsigned k = j + d; k < top; k += d) begin
                    x += tab_rd(i - 1, k);
                    tab_wr(i, k, x);
                end
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            d = w[i + 1];
            for (int unsigned j = 0; j < d && j < top; j++) begin
                x = 0;
                for (int unsigned k = j; k < top; k += d) begin
                    y = tab_rd(i, k);
                    tab_wr(i, k, x);
                    x += y;
                end
            end
        end
        tab_wr(n, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        pm_n = n;
        for (int i = 0; i <= n; i++) pm_w[i] = w[i];
        pm_hint = 1;
    endfunction

    function automatic int unsigned find_total_degree(bit [63:0] v);
        int unsigned c, d;
        c = pm_n - 1;
        d = pm_hint;
        if (d < 1) d = 1;
        if (d > pm_top) d = pm_top;
        if (tab_rd(c, d) <= v) begin
            while (d < pm_top && tab_rd(c, d) <= v) d++;
            pm_hint = d;
            d--;
        end else begin
            d--;
            if (tab_rd(c, d) > v) begin
                while (d > 0 && tab_rd(c, d) > v) d--;
                pm_hint = d + 1;
            end
        end
        return d;
    endfunction

    function automatic mono_res_t predict_monomial_result(mono_req_t r);
        mono_res_t res;
        bit [63:0] v, s;
        int unsigned d, i, up, maxdeg;
        res.status = wmr_pkg::STAT_OK;
        res.dec = '{default: 8'd0};
        s = 0;
        v = r.rank;
        if (r.kind == wmr_pkg::REQ_BUILD) begin
            build_rank_table();
            s = pm_max_rank;
        end else if (pm_top == 0) begin
            res.status = (r.kind == wmr_pkg::REQ_ENCODE) ? wmr_pkg::STAT_DEGREE
                                                         : wmr_pkg::STAT_RANK;
        end else begin
            maxdeg = pm_top - 1;
            if (r.kind == wmr_pkg::REQ_ENCODE) begin
                for (int k = 0; k < pm_n; k++) begin
                    if (r.exps[k] > maxdeg) res.status = wmr_pkg::STAT_DEGREE;
                    else s += tab_rd(k, r.exps[k]);
                end
            end else if (v > pm_max_rank) begin
                res.status = wmr_pkg::STAT_RANK;
            end else begin
                d = find_total_degree(v);
                i = pm_n - 1;
                forever begin
                    if (r.kind == wmr_pkg::REQ_DECODE) res.dec[i] = 8'(d);
                    else if (d + r.exps[i] > maxdeg) begin
                        res.status = wmr_pkg::STAT_DEGREE;
                        break;
                    end else s += tab_rd(i, d + r.exps[i]);
                    v -= tab_rd(i, d);
                    if (i == 0) break;
                    i--;
                    up = pm_w[i + 1];
                    while (d >= up && tab_rd(i, d) > v) d -= up;
                end
                if (r.kind == wmr_pkg::REQ_DECODE) s = 0;
            end
        end
        if (res.status != wmr_pkg::STAT_OK) begin
            s = 0;
            res.dec = '{default: 8'd0};
        end
        res.rank = s;
        res.top = pm_top ? 8'(pm_top - 1) : 8'd0;
        return res;
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_monomial_result(cur_req));
                n_kind[cur_req.kind]++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid <= 1;
                    s_req_type <= cur_req.kind;
                    s_rank_in <= cur_req.rank;
                    for (int k = 0; k < 8; k++) s_exp[k] <= cur_req.exps[k];
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        mono_res_t exp_r;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d rank %h",
                             $time, m_status, m_rank_out);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    n_checked++;
                    if (exp_r.status != wmr_pkg::STAT_OK) n_bad_status++;
                    if (m_status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_status);
                        errors++;
                    end
                    if (m_rank_out !== exp_r.rank) begin
                        $display("%0t: rank_out expected %h actual %h",
                                 $time, exp_r.rank, m_rank_out);
                        errors++;
                    end
                    for (int k = 0; k < 8; k++) begin
                        if (m_dec[k] !== exp_r.dec[k]) begin
                            $display("%0t: dec_%0d expected %0d actual %0d",
                                     $time, k, exp_r.dec[k], m_dec[k]);
                            errors++;
                        end
                    end
                    if (m_top_degree !== exp_r.top) begin
                        $display("%0t: top_degree expected %0d actual %0d",
                                 $time, exp_r.top, m_top_degree);
                        errors++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done <= 1;
                hold_cnt <= 600;
                m_ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= 0;
            end else begin
                m_ready <= no_idle || $urandom_range(0, 99) >= 7;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        case (idx)
            wmr_pkg::CFG_NUM_VARS:    cf_nvars = val & 15;
            wmr_pkg::CFG_VAR_WEIGHTS: cf_weights = val;
            wmr_pkg::CFG_MAX_DEGREE:  cf_maxdeg = val & 255;
            wmr_pkg::CFG_LAST_STEP:   cf_step = val & 15;
            default: ;
        endcase
    endtask

    task automatic drain(int settle);
        @(negedge aclk);
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic mono_req_t make_req(wmr_pkg::req_t kind, logic [63:0] rank,
                                           int unsigned e);
        mono_req_t r;
        r.kind = kind;
        r.rank = rank;
        for (int k = 0; k < 8; k++) r.exps[k] = 8'(e);
        return r;
    endfunction

    function automatic logic [63:0] pick_rank();
        logic [63:0] r;
        int sel;
        sel = $urandom_range(0, 99);
        r = {$urandom, $urandom};
        if (sel < 10) return 0;
        if (sel < 20) return pm_max_rank;
        if (sel < 28 && pm_max_rank != 64'hFFFF_FFFF_FFFF_FFFF) return pm_max_rank + 1;
        if (sel < 36) return r;
        if (pm_max_rank == 64'hFFFF_FFFF_FFFF_FFFF) return r;
        return r % (pm_max_rank + 1);
    endfunction

    // Cumulative exponents: non-decreasing up to lim in the used columns.
    function automatic mono_req_t random_req();
        mono_req_t r;
        int sel, lim, prev;
        sel = $urandom_range(0, 99);
        r.rank = pick_rank();
        for (int k = 0; k < 8; k++) r.exps[k] = 8'($urandom_range(0, 255));
        lim = pm_top - 1;
        if (sel >= 34 && sel < 62) r.kind = wmr_pkg::REQ_DECODE;
        else if (sel >= 62) r.kind = wmr_pkg::REQ_MULTIPLY;
        else r.kind = wmr_pkg::REQ_ENCODE;
        if (r.kind == wmr_pkg::REQ_MULTIPLY) lim = (lim < 4) ? lim : lim / 4;
        if (sel < 3) begin
            r.kind = wmr_pkg::REQ_BUILD;
        end else if (sel < 92) begin
            prev = 0;
            for (int k = 0; k < pm_n; k++) begin
                prev = prev + $urandom_range(0, lim - prev);
                r.exps[k] = 8'(prev);
            end
            if ($urandom_range(0, 9) == 0 && pm_top < 256)
                r.exps[$urandom_range(0, pm_n - 1)] = 8'($urandom_range(pm_top, 255));
        end else begin
            r.kind = wmr_pkg::req_t'($urandom_range(1, 3));
            r.rank = {$urandom, $urandom};
        end
        return r;
    endfunction

    initial begin
        int unsigned nv, wt, md, ls;
        cf_nvars = 1;
        cf_weights = 32'h1111_1111;
        cf_maxdeg = 255;
        cf_step = 1;
        pm_top = 0;
        pm_hint = 1;
        pm_n = 1;
        pm_max_rank = 0;
        pm_w = '{default: 0};
        pm_w[0] = 1;
        pm_w[1] = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1;

        // Requests before any build must all report errors.
        pending_reqs.push_back(make_req(wmr_pkg::REQ_ENCODE, 0, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, 0, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_MULTIPLY, 64'hFFFF_FFFF_FFFF_FFFF, 255));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_BUILD, 0, 0));
        drain(0);
        pending_reqs.push_back(make_req(wmr_pkg::REQ_ENCODE, 0, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_ENCODE, 0, 255));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_ENCODE, 0, pm_top - 1));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, 0, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, pm_max_rank, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, pm_max_rank + 1, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 255));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_MULTIPLY, pm_max_rank, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_MULTIPLY, 0, 255));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_MULTIPLY, 5, 1));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_BUILD, 0, 0));
        pending_reqs.push_back(make_req(wmr_pkg::REQ_DECODE, 1, 0));
        drain(10);

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin nv = 0; wt = 0; md = 0; ls = 0; end
                1: begin nv = 15; wt = 32'hFFFF_FFFF; md = 255; ls = 15; end
                2: begin nv = 8; wt = 32'h1111_1111; md = 255; ls = 1; end
                3: begin nv = 3; wt = 32'h0000_0321; md = 40; ls = 1; end
                4: begin nv = 1; wt = 32'h0000_000F; md = 1; ls = 2; end
                default: begin
                    nv = $urandom_range(1, 8);
                    wt = $urandom;
                    md = $urandom_range(1, (ph % 4 == 0) ? 255 : 60);
                    ls = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 1;
                end
            endcase
            no_idle = (ph == 6);
            write_reg(wmr_pkg::CFG_NUM_VARS, nv);
            write_reg(wmr_pkg::CFG_VAR_WEIGHTS, wt);
            write_reg(wmr_pkg::CFG_MAX_DEGREE, md);
            write_reg(wmr_pkg::CFG_LAST_STEP, ls);
            pending_reqs.push_back(make_req(wmr_pkg::REQ_BUILD, 0, 0));
            drain(0);
            for (int k = 0; k < 125; k++) begin
                pending_reqs.push_back(random_req());
                if (k == 60 && ph == 3) hold_request = 1;
                // The sender waits here until every result is back.
                if (k == 60 && ph == 5) drain(0);
            end
            drain(10);
        end

        $display("Checked %0d results: %0d builds, %0d encodes, %0d decodes, %0d multiplies,",
                 n_checked, n_kind[wmr_pkg::REQ_BUILD], n_kind[wmr_pkg::REQ_ENCODE],
                 n_kind[wmr_pkg::REQ_DECODE], n_kind[wmr_pkg::REQ_MULTIPLY]);
        $display("%0d of them error statuses, over 13 table configurations.", n_bad_status);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
